// ===== hw/rtl/rbs_pkg.sv =====
package rbs_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int EPS_W   = 17;
    // |bound - origin| in doubled units stays below 2^34
    localparam int DIFF_W  = 34;
    // |2*dir| is at most 2^32
    localparam int DEN_W   = 33;

    localparam logic [1:0] ST_MISS = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] box_center_x;
        logic signed [COORD_W-1:0] box_center_y;
        logic signed [COORD_W-1:0] box_center_z;
        logic        [SIZE_W-1:0]  box_size_x;
        logic        [SIZE_W-1:0]  box_size_y;
        logic        [SIZE_W-1:0]  box_size_z;
    } t_ray_in;

    typedef struct packed {
        logic        [1:0]         status;
        logic signed [COORD_W-1:0] entry_time;
    } t_ray_out;

    // per-axis flags that ride alongside the divider
    typedef struct packed {
        logic flat;     // direction counts as zero
        logic outside;  // origin outside slab
        logic lo_neg;   // sign of low-bound quotient
        logic hi_neg;   // sign of high-bound quotient
    } t_axis_ctl;

    typedef struct packed {
        t_axis_ctl          ctl;
        logic [DIFF_W-1:0]  lo_mag;
        logic [DIFF_W-1:0]  hi_mag;
        logic [DEN_W-1:0]   den_mag;
    } t_axis_prep;

endpackage

// ===== hw/rtl/rbs_prep.sv =====
module rbs_prep
    import rbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_ray_in               i_item,
    input  logic [EPS_W-1:0]      i_eps,
    output logic                  o_valid,
    output t_axis_prep [2:0]      o_prep
);

    logic              r_valid;
    t_axis_prep [2:0]  r_prep;
    t_axis_prep [2:0]  n_prep;

    function automatic t_axis_prep prep_axis(
        input logic signed [COORD_W-1:0] o,
        input logic signed [COORD_W-1:0] d,
        input logic signed [COORD_W-1:0] c,
        input logic        [SIZE_W-1:0]  s,
        input logic        [EPS_W-1:0]   eps
    );
        logic signed [DIFF_W:0] o2;
        logic signed [DIFF_W:0] lo;
        logic signed [DIFF_W:0] hi;
        logic signed [DIFF_W:0] dl;
        logic signed [DIFF_W:0] dh;
        logic        [COORD_W-1:0] absd;
        t_axis_prep  p;
        o2   = (DIFF_W+1)'(o) <<< 1;
        lo   = ((DIFF_W+1)'(c) <<< 1) - $signed({4'b0, s});
        hi   = ((DIFF_W+1)'(c) <<< 1) + $signed({4'b0, s});
        dl   = lo - o2;
        dh   = hi - o2;
        absd = d[COORD_W-1] ? COORD_W'(-d) : COORD_W'(d);
        p.ctl.flat    = (d == '0) || (absd < {{(COORD_W-EPS_W){1'b0}}, eps});
        p.ctl.outside = (o2 < lo) || (o2 > hi);
        p.ctl.lo_neg  = dl[DIFF_W] ^ d[COORD_W-1];
        p.ctl.hi_neg  = dh[DIFF_W] ^ d[COORD_W-1];
        p.lo_mag      = dl[DIFF_W] ? DIFF_W'(-dl) : dl[DIFF_W-1:0];
        p.hi_mag      = dh[DIFF_W] ? DIFF_W'(-dh) : dh[DIFF_W-1:0];
        p.den_mag     = {absd, 1'b0};
        return p;
    endfunction

    always_comb begin
        n_prep[0] = prep_axis(i_item.origin_x, i_item.dir_x, i_item.box_center_x,
                              i_item.box_size_x, i_eps);
        n_prep[1] = prep_axis(i_item.origin_y, i_item.dir_y, i_item.box_center_y,
                              i_item.box_size_y, i_eps);
        n_prep[2] = prep_axis(i_item.origin_z, i_item.dir_z, i_item.box_center_z,
                              i_item.box_size_z, i_eps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prep <= n_prep;
    end

    assign o_valid = r_valid;
    assign o_prep  = r_prep;

endmodule

// ===== hw/rtl/rbs_div.sv =====
module rbs_div #(
    parameter int NW = 50,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    // one quotient bit per stage, restoring
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [NW-1:0] p_num;
            logic [NW-1:0] p_quo;
            logic [DW-1:0] p_rem;
            logic [DW-1:0] p_den;
            logic [DW:0]   cand;
            logic          fit;
            if (k == 0) begin : g_first
                assign p_num = i_num;
                assign p_quo = '0;
                assign p_rem = '0;
                assign p_den = i_den;
            end else begin : g_next
                assign p_num = r_num[k-1];
                assign p_quo = r_quo[k-1];
                assign p_rem = r_rem[k-1];
                assign p_den = r_den[k-1];
            end
            assign cand = {p_rem, p_num[NW-1]};
            assign fit  = cand >= {1'b0, p_den};
            always_ff @(posedge i_clk) begin
                r_num[k] <= {p_num[NW-2:0], 1'b0};
                r_quo[k] <= {p_quo[NW-2:0], fit};
                r_rem[k] <= fit ? DW'(cand - {1'b0, p_den}) : cand[DW-1:0];
                r_den[k] <= p_den;
            end
        end
    endgenerate

    assign o_quo = r_quo[NW-1];

endmodule

// ===== hw/rtl/rbs_merge.sv =====
module rbs_merge
    import rbs_pkg::*;
#(
    parameter int TW = 50
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_axis_ctl [2:0]            i_ctl,
    input  logic signed [TW-1:0]       i_t_lo [3],
    input  logic signed [TW-1:0]       i_t_hi [3],
    output logic                       o_strobe,
    output t_ray_out                   o_result
);

    localparam logic signed [TW-1:0] T_MAX = {{(TW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [TW-1:0] T_MIN = {{(TW-31){1'b1}}, 31'b0};

    // stage 1: order slab times per axis
    logic                      r1_valid;
    logic [2:0]                r1_flat;
    logic                      r1_out;
    logic signed [TW-1:0]      r1_tmin [3];
    logic signed [TW-1:0]      r1_tmax [3];

    // stage 2: running entry max / exit min
    logic                      r2_valid;
    logic                      r2_out;
    logic                      r2_con;
    logic signed [TW-1:0]      r2_enter;
    logic signed [TW-1:0]      r2_exit;
    logic                      n2_con;
    logic signed [TW-1:0]      n2_enter;
    logic signed [TW-1:0]      n2_exit;

    logic                      r3_valid;
    t_ray_out                  r3_result;
    t_ray_out                  n3_result;

    always_comb begin
        n2_con   = 1'b0;
        n2_enter = '0;
        n2_exit  = '0;
        for (int a = 0; a < 3; a++) begin
            if (!r1_flat[a]) begin
                if (!n2_con) begin
                    n2_enter = r1_tmin[a];
                    n2_exit  = r1_tmax[a];
                end else begin
                    if (r1_tmin[a] > n2_enter) n2_enter = r1_tmin[a];
                    if (r1_tmax[a] < n2_exit)  n2_exit  = r1_tmax[a];
                end
                n2_con = 1'b1;
            end
        end
    end

    always_comb begin
        n3_result.status     = ST_HIT;
        n3_result.entry_time = r2_enter[COORD_W-1:0];
        if (r2_out || (r2_con && (r2_enter > r2_exit))) begin
            n3_result.status     = ST_MISS;
            n3_result.entry_time = '0;
        end else if (!r2_con) begin
            n3_result.status     = ST_FREE;
            n3_result.entry_time = T_MIN[COORD_W-1:0];
        end else if (r2_enter > T_MAX) begin
            n3_result.entry_time = T_MAX[COORD_W-1:0];
        end else if (r2_enter < T_MIN) begin
            n3_result.entry_time = T_MIN[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        for (int a = 0; a < 3; a++) begin
            r1_flat[a] <= i_ctl[a].flat;
            r1_tmin[a] <= (i_t_lo[a] > i_t_hi[a]) ? i_t_hi[a] : i_t_lo[a];
            r1_tmax[a] <= (i_t_lo[a] > i_t_hi[a]) ? i_t_lo[a] : i_t_hi[a];
        end
        r1_out    <= (i_ctl[0].flat && i_ctl[0].outside)
                  || (i_ctl[1].flat && i_ctl[1].outside)
                  || (i_ctl[2].flat && i_ctl[2].outside);
        r2_out    <= r1_out;
        r2_con    <= n2_con;
        r2_enter  <= n2_enter;
        r2_exit   <= n2_exit;
        r3_result <= n3_result;
    end

    assign o_strobe = r3_valid;
    assign o_result = r3_result;

endmodule

// ===== hw/rtl/ray_box_slab_intersection_top.sv =====
// Ray versus axis-aligned box, slab test, Q16.16 fixed point.
// Pipeline: the prep register, then the restoring dividers, which retire one
//   quotient bit per stage, then the merge stages.
// Throughput: one beat per cycle; busy is never raised and the receiver cannot stall.
// Reset: synchronous, active low; clears all valid bits, epsilon returns to 1.
module ray_box_slab_intersection_top
    import rbs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_wdata,
    input  t_ray_in          i_item,
    output logic             o_strobe,
    output t_ray_out         o_result
);

    // quotient width; also the depth of the divider pipes
    localparam int NW = DIFF_W + FRAC_BITS;

    // direction epsilon register
    logic [EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // fully pipelined, so a beat is taken every cycle
    assign busy = 1'b0;

    // stage 0: bounds, differences, magnitudes, flat / outside flags
    logic             prep_valid;
    t_axis_prep [2:0] prep;

    rbs_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .i_eps   (r_eps),
        .o_valid (prep_valid),
        .o_prep  (prep)
    );

    // six divider lanes: low and high bound for each axis.
    // Numerator is 2*|bound - origin| scaled by 2^FRAC_BITS, denominator |2*dir|.
    logic [NW-1:0] quo_lo [3];
    logic [NW-1:0] quo_hi [3];

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            rbs_div #(.NW(NW), .DW(DEN_W)) u_div_lo (
                .i_clk (i_clk),
                .i_num ({prep[a].lo_mag, {FRAC_BITS{1'b0}}}),
                .i_den (prep[a].den_mag),
                .o_quo (quo_lo[a])
            );
            rbs_div #(.NW(NW), .DW(DEN_W)) u_div_hi (
                .i_clk (i_clk),
                .i_num ({prep[a].hi_mag, {FRAC_BITS{1'b0}}}),
                .i_den (prep[a].den_mag),
                .o_quo (quo_hi[a])
            );
        end
    endgenerate

    // flags and valid bit delayed to match the dividers
    logic            r_sb_valid [NW];
    t_axis_ctl [2:0] r_sb_ctl   [NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_sb_valid[k] <= 1'b0;
        end else begin
            r_sb_valid[0] <= prep_valid;
            for (int k = 1; k < NW; k++) r_sb_valid[k] <= r_sb_valid[k-1];
        end
        for (int k = 0; k < 3; k++) r_sb_ctl[0][k] <= prep[k].ctl;
        for (int k = 1; k < NW; k++) r_sb_ctl[k] <= r_sb_ctl[k-1];
    end

    // restore the quotient signs; truncation toward zero falls out of
    // dividing magnitudes. Quotient stays below 2^(NW-1) on non-flat axes, where |2*dir| >= 2.
    t_axis_ctl [2:0]            sb_ctl;
    logic signed [NW-1:0]       t_lo [3];
    logic signed [NW-1:0]       t_hi [3];

    always_comb begin
        sb_ctl = r_sb_ctl[NW-1];
        for (int k = 0; k < 3; k++) begin
            t_lo[k] = sb_ctl[k].lo_neg ? NW'(-quo_lo[k]) : quo_lo[k];
            t_hi[k] = sb_ctl[k].hi_neg ? NW'(-quo_hi[k]) : quo_hi[k];
        end
    end

    // three stages: order, running max/min, hit decision and saturation
    rbs_merge #(.TW(NW)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_sb_valid[NW-1]),
        .i_ctl    (sb_ctl),
        .i_t_lo   (t_lo),
        .i_t_hi   (t_hi),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_MISS) |-> o_result.entry_time == '0)
        else $error("miss beat with nonzero entry time");

    a_free_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_FREE)
            |-> o_result.entry_time == {1'b1, {(COORD_W-1){1'b0}}})
        else $error("unconstrained hit without minimum entry time");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_sb_valid[NW-1], 3))
        else $error("result beat without a beat leaving the dividers");

endmodule
